@@ sv/ismu_pkg.sv @@
`timescale 1ns / 1ps

package ismu_pkg;

	localparam int MEM_SITES = 4096;
	localparam int STRIDE_CAP = 1048576;
	localparam int RECIP_SH = 24;

	localparam int CMD_W = 2;
	localparam int SITE_W = 12;
	localparam int RND_W = 32;
	localparam int LVL_FW = 3;
	localparam int THR_W = 33;
	localparam int CNT_W = 13;
	localparam int CHG_W = 14;

	localparam int DEF_SIDE = 64;
	localparam int DEF_DIMS = 2;

	localparam logic [THR_W-1:0] THR_MAX = 33'h1_0000_0000;

	localparam logic [CMD_W-1:0] CMD_TRIAL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_MOD,
		ST_NB,
		ST_LAST,
		ST_DECIDE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clear;
		logic mul;
		logic modr;
		logic nb_rd;
		logic fire;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic in_trial;
		logic nb_last;
		logic out_free;
	} sts_t;

	// stride of axis d, capped as the lattice grows
	function automatic longint ax_stride(input int side, input int d);
		longint s;
		s = 1;
		for (int i = 0; i < d; i++) begin
			s = s * side;
			if (s > STRIDE_CAP)
				s = STRIDE_CAP;
		end
		return s;
	endfunction

	function automatic int stored_sites(input int side, input int dims);
		longint s;
		s = ax_stride(side, dims);
		return (s < MEM_SITES) ? int'(s) : MEM_SITES;
	endfunction

endpackage

@@ sv/ismu_ctrl.sv @@
`timescale 1ns / 1ps

module ismu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ismu_pkg::sts_t sts,
	output ismu_pkg::ctl_t ctl
);

	ismu_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ismu_pkg::ST_CLEAR;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ismu_pkg::ST_CLEAR: begin
				if (sts.clear_done)
					state_nxt = ismu_pkg::ST_IDLE;
			end
			ismu_pkg::ST_IDLE: begin
				if (in_valid)
					state_nxt = sts.in_trial ? ismu_pkg::ST_MUL : ismu_pkg::ST_DECIDE;
			end
			ismu_pkg::ST_MUL:  state_nxt = ismu_pkg::ST_MOD;
			ismu_pkg::ST_MOD:  state_nxt = ismu_pkg::ST_NB;
			ismu_pkg::ST_NB: begin
				if (sts.nb_last)
					state_nxt = ismu_pkg::ST_LAST;
			end
			ismu_pkg::ST_LAST: state_nxt = ismu_pkg::ST_DECIDE;
			ismu_pkg::ST_DECIDE: begin
				if (sts.out_free)
					state_nxt = ismu_pkg::ST_IDLE;
			end
			default: state_nxt = ismu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		in_stall = 1'b1;
		case (state_q)
			ismu_pkg::ST_CLEAR: ctl.clear = 1'b1;
			ismu_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				ctl.capture = in_valid;
			end
			ismu_pkg::ST_MUL:    ctl.mul = 1'b1;
			ismu_pkg::ST_MOD:    ctl.modr = 1'b1;
			ismu_pkg::ST_NB:     ctl.nb_rd = 1'b1;
			ismu_pkg::ST_LAST:   ctl = '0;
			ismu_pkg::ST_DECIDE: ctl.fire = sts.out_free;
			default:             ctl = '0;
		endcase
	end

endmodule

@@ sv/ismu_dp.sv @@
`timescale 1ns / 1ps

module ismu_dp #(
	parameter int SIDE = ismu_pkg::DEF_SIDE,
	parameter int DIMS = ismu_pkg::DEF_DIMS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ismu_pkg::ctl_t                      ctl,
	output ismu_pkg::sts_t                      sts,
	input  logic [ismu_pkg::CMD_W-1:0]          command,
	input  logic [ismu_pkg::SITE_W-1:0]         site_index,
	input  logic [ismu_pkg::RND_W-1:0]          random_fraction,
	input  logic [ismu_pkg::LVL_FW-1:0]         energy_level,
	input  logic [ismu_pkg::THR_W-1:0]          threshold_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                flipped,
	output logic [ismu_pkg::CNT_W-1:0]          up_count,
	output logic signed [ismu_pkg::CHG_W-1:0]   count_change
);

	localparam int SITE_W = ismu_pkg::SITE_W;
	localparam int CNT_W = ismu_pkg::CNT_W;
	localparam int CHG_W = ismu_pkg::CHG_W;
	localparam int THR_W = ismu_pkg::THR_W;
	localparam int NB_W = $clog2(ismu_pkg::MEM_SITES * SIDE);
	localparam int UW = $clog2(2 * DIMS + 1);
	localparam int NI_W = $clog2(2 * DIMS);
	localparam int AX_W = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int PW = SITE_W + ismu_pkg::RECIP_SH;
	localparam logic [CNT_W-1:0] STORED = CNT_W'(ismu_pkg::stored_sites(SIDE, DIMS));
	localparam logic [SITE_W-1:0] LAST_SITE = SITE_W'(STORED - 1'b1);

	// request registers
	logic [ismu_pkg::CMD_W-1:0]  cmd_q;
	logic [SITE_W-1:0]           site_q;
	logic [ismu_pkg::RND_W-1:0]  rnd_q;
	logic [ismu_pkg::LVL_FW-1:0] lvl_q;
	logic [THR_W-1:0]            thr_q;
	logic                        trial_q;

	assign sts.in_trial = (command == ismu_pkg::CMD_TRIAL) &&
		({1'b0, site_index} < STORED);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= command;
			site_q <= site_index;
			rnd_q <= random_fraction;
			lvl_q <= energy_level;
			thr_q <= threshold_value;
			trial_q <= sts.in_trial;
		end
	end

	// per-axis geometry and wrap detection
	logic [NB_W-1:0] st_c [DIMS];
	logic [NB_W-1:0] wr_c [DIMS];
	logic            big_c [DIMS];
	logic            lo_q [DIMS];
	logic            hi_q [DIMS];

	for (genvar d = 0; d < DIMS; d++) begin : g_axis
		localparam longint ST = ismu_pkg::ax_stride(SIDE, d);
		localparam longint HI = (SIDE - 1) * ST;
		localparam longint P = ST * SIDE;

		if (ST >= ismu_pkg::MEM_SITES) begin : g_big
			// every neighbour on this axis lies outside the store
			assign st_c[d] = '0;
			assign wr_c[d] = '0;
			assign big_c[d] = 1'b1;
			assign lo_q[d] = 1'b0;
			assign hi_q[d] = 1'b0;
		end else begin : g_small
			assign st_c[d] = NB_W'(ST);
			assign wr_c[d] = NB_W'(HI);
			assign big_c[d] = 1'b0;

			if (P >= ismu_pkg::MEM_SITES) begin : g_direct
				always_ff @(posedge clk) begin
					if (ctl.modr) begin
						lo_q[d] <= {20'd0, site_q} < 32'(ST);
						hi_q[d] <= {20'd0, site_q} >= 32'(HI);
					end
				end
			end else begin : g_recip
				localparam longint M = (64'd1 << ismu_pkg::RECIP_SH) / P;
				logic [SITE_W-1:0]   q_s1;
				logic [PW-1:0]       prod;
				logic [2*SITE_W-1:0] qp;
				logic [SITE_W:0]     r0;
				logic [SITE_W:0]     r;

				// quotient estimate is exact or one short
				assign prod = PW'(site_q) * PW'(M);
				assign qp = (2 * SITE_W)'(q_s1) * (2 * SITE_W)'(P);
				assign r0 = {1'b0, site_q} - qp[SITE_W:0];
				assign r = (r0 >= (SITE_W + 1)'(P)) ? r0 - (SITE_W + 1)'(P) : r0;

				always_ff @(posedge clk) begin
					if (ctl.mul)
						q_s1 <= prod[PW-1:ismu_pkg::RECIP_SH];
					if (ctl.modr) begin
						lo_q[d] <= r < (SITE_W + 1)'(ST);
						hi_q[d] <= r >= (SITE_W + 1)'(HI);
					end
				end
			end
		end
	end

	// neighbour sequencing
	logic [NI_W-1:0] nb_q;
	logic [AX_W-1:0] ax;
	logic [NB_W-1:0] site_x;
	logic [NB_W-1:0] nb_addr;
	logic            oob;

	assign ax = AX_W'(nb_q >> 1);
	assign site_x = NB_W'(site_q);
	assign sts.nb_last = nb_q == NI_W'(2 * DIMS - 1);

	always_comb begin
		if (!nb_q[0])
			nb_addr = hi_q[ax] ? site_x - wr_c[ax] : site_x + st_c[ax];
		else
			nb_addr = lo_q[ax] ? site_x + wr_c[ax] : site_x - st_c[ax];
	end

	assign oob = big_c[ax] || (nb_addr >= NB_W'(ismu_pkg::MEM_SITES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			nb_q <= '0;
		else if (ctl.modr)
			nb_q <= '0;
		else if (ctl.nb_rd)
			nb_q <= nb_q + 1'b1;
	end

	// spin memory
	logic                 mem [ismu_pkg::MEM_SITES];
	logic [SITE_W-1:0]    clr_ptr_q;
	logic                 rdata_q;
	logic                 mem_we;
	logic [SITE_W-1:0]    mem_wa;
	logic                 mem_wd;
	logic [SITE_W-1:0]    mem_ra;
	logic                 do_flip;
	logic                 spin_q;

	assign sts.clear_done = clr_ptr_q == LAST_SITE;
	assign mem_we = ctl.clear || (ctl.fire && do_flip);
	assign mem_wa = ctl.clear ? clr_ptr_q : site_q;
	assign mem_wd = ctl.clear ? 1'b1 : ~spin_q;
	assign mem_ra = ctl.mul ? site_q : nb_addr[SITE_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_ptr_q <= '0;
		else if (ctl.clear)
			clr_ptr_q <= clr_ptr_q + 1'b1;
	end

	// neighbour count: read data lands in the cycle after the address
	logic          pend_q;
	logic          forced_q;
	logic [UW-1:0] up_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= 1'b0;
		else
			pend_q <= ctl.nb_rd;
	end

	always_ff @(posedge clk) begin
		forced_q <= oob;
		if (ctl.modr) begin
			spin_q <= rdata_q;
			up_q <= '0;
		end else if (pend_q) begin
			up_q <= up_q + UW'(forced_q || rdata_q);
		end
	end

	// acceptance decision
	logic [THR_W-1:0] tbl_q [DIMS];
	logic [CNT_W-1:0] cur_q;
	logic [CNT_W-1:0] rep_q;
	logic             pos;
	logic [UW-1:0]    idx;
	logic             accept;
	logic [CNT_W-1:0] cur_nxt;
	logic [CHG_W-1:0] change;

	always_comb begin
		if (spin_q) begin
			pos = up_q > UW'(DIMS);
			idx = up_q - UW'(DIMS) - 1'b1;
		end else begin
			pos = up_q < UW'(DIMS);
			idx = UW'(DIMS) - up_q - 1'b1;
		end
	end

	assign accept = !pos || ({1'b0, rnd_q} < tbl_q[AX_W'(idx)]);
	assign do_flip = (cmd_q == ismu_pkg::CMD_TRIAL) && trial_q && accept;

	always_comb begin
		if (!do_flip)
			cur_nxt = cur_q;
		else if (spin_q)
			cur_nxt = cur_q - 1'b1;
		else
			cur_nxt = cur_q + 1'b1;
	end

	assign change = CHG_W'(cur_q) - CHG_W'(rep_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= STORED;
			rep_q <= STORED;
			for (int i = 0; i < DIMS; i++)
				tbl_q[i] <= '0;
		end else if (ctl.fire) begin
			cur_q <= cur_nxt;
			if (cmd_q == ismu_pkg::CMD_REPORT)
				rep_q <= cur_q;
			if ((cmd_q == ismu_pkg::CMD_LOAD) && (4'(lvl_q) < 4'(DIMS)))
				tbl_q[AX_W'(lvl_q)] <= (thr_q > ismu_pkg::THR_MAX) ? ismu_pkg::THR_MAX : thr_q;
		end
	end

	// output register
	logic out_valid_q;

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			flipped <= do_flip;
			up_count <= cur_nxt;
			count_change <= (cmd_q == ismu_pkg::CMD_REPORT) ? signed'(change) : '0;
		end
	end

endmodule

@@ sv/ising_metropolis_lattice_update.sv @@
`timescale 1ns / 1ps
// channel   handshake                 payload
// in        in_valid / in_stall       command, site_index, random_fraction,
//                                     energy_level, threshold_value
// out       out_valid / out_stall     flipped, up_count, count_change
//
// A trial passes the multiply and modulo states, then one spin memory read
// per neighbour, then a last state and the decision step. Load, report, the
// unused command and a trial on a site outside the store go from idle to the
// decision step. After reset a clearing pass writes every stored spin up, one
// per cycle (SIDE^DIMS capped at 4096 spins); in_stall is high meanwhile.
// A result waits in the output register while the next request is accepted;
// the decision step holds while that register is still full and stalled.

module ising_metropolis_lattice_update #(
	parameter int SIDE = ismu_pkg::DEF_SIDE,
	parameter int DIMS = ismu_pkg::DEF_DIMS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ismu_pkg::CMD_W-1:0]        command,
	input  logic [ismu_pkg::SITE_W-1:0]       site_index,
	input  logic [ismu_pkg::RND_W-1:0]        random_fraction,
	input  logic [ismu_pkg::LVL_FW-1:0]       energy_level,
	input  logic [ismu_pkg::THR_W-1:0]        threshold_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              flipped,
	output logic [ismu_pkg::CNT_W-1:0]        up_count,
	output logic signed [ismu_pkg::CHG_W-1:0] count_change
);

	ismu_pkg::ctl_t ctl;
	ismu_pkg::sts_t sts;

	ismu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	ismu_dp #(
		.SIDE (SIDE),
		.DIMS (DIMS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.command         (command),
		.site_index      (site_index),
		.random_fraction (random_fraction),
		.energy_level    (energy_level),
		.threshold_value (threshold_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.flipped         (flipped),
		.up_count        (up_count),
		.count_change    (count_change)
	);

endmodule
